// ===== rtl/core/y2n_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and chroma arithmetic for the YUY2 to NV12 chroma downsampler.
// Used by y2n_line_store and yuy2_to_nv12_chroma_downsampler_top; depends on nothing.
package y2n_pkg;

  localparam int unsigned DefaultMaxPairs = 1024;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 11;
  localparam int unsigned LinePairsWidth = 11;
  localparam logic [LinePairsWidth-1:0] LinePairsReset = 11'd960;

  localparam logic [CfgIndexWidth-1:0] RegLinePairs = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegInterlaced = 2'd1;

  typedef enum logic [1:0] {
    MIX_NONE,
    MIX_AVERAGE,
    MIX_HEAVY_STORED,
    MIX_HEAVY_CURRENT
  } mix_op_t;

  typedef struct packed {
    logic rd;
    logic wr_first;
    logic wr_second;
  } store_cmd_t;

  function automatic logic [7:0] chroma_mix(input mix_op_t op, input logic [7:0] stored,
                                            input logic [7:0] current);
    logic [9:0] sum;
    logic [7:0] result;
    sum = 10'd0;
    result = 8'd0;
    unique case (op)
      MIX_NONE: begin
        result = 8'd0;
      end
      MIX_AVERAGE: begin
        sum = {2'b00, stored} + {2'b00, current} + 10'd1;
        result = sum[8:1];
      end
      MIX_HEAVY_STORED: begin
        sum = {2'b00, stored} + {1'b0, stored, 1'b0} + {2'b00, current} + 10'd2;
        result = sum[9:2];
      end
      MIX_HEAVY_CURRENT: begin
        sum = {2'b00, current} + {1'b0, current, 1'b0} + {2'b00, stored} + 10'd2;
        result = sum[9:2];
      end
      default: begin
        result = 8'd0;
      end
    endcase
    return result;
  endfunction

endpackage

// ===== rtl/core/y2n_line_store.sv =====
`timescale 1ns / 1ps
// Two chroma line stores with registered reads.
// Depends on y2n_pkg for the store command structure.
module y2n_line_store #(
  parameter int unsigned MAX_PAIRS = y2n_pkg::DefaultMaxPairs
) (
  input  logic                         clk,
  input  y2n_pkg::store_cmd_t          cmd,
  input  logic [$clog2(MAX_PAIRS)-1:0] addr,
  input  logic [15:0]                  wdata,
  output logic [15:0]                  rdata_first,
  output logic [15:0]                  rdata_second
);

  logic [15:0] store_first [MAX_PAIRS];
  logic [15:0] store_second [MAX_PAIRS];

  always_ff @(posedge clk) begin
    if (cmd.wr_first) begin
      store_first[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_first <= store_first[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_second) begin
      store_second[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_second <= store_second[addr];
    end
  end

endmodule

// ===== rtl/core/yuy2_to_nv12_chroma_downsampler_top.sv =====
`timescale 1ns / 1ps
// Top level of the YUY2 to NV12 chroma downsampler: counters, control and output register.
// Depends on y2n_pkg and y2n_line_store.
// The block accepts one pixel pair per clock while in_stall is low and returns one result
// per pair through the s1 stage and the output register. Lines that begin a vertical group
// write their chroma to a line store, and lines that complete it read the stored chroma of
// the same column and mix it with the incoming one.
// Luma passes through unchanged. Configuration must be written while the block is idle.
module yuy2_to_nv12_chroma_downsampler_top #(
  parameter int unsigned MAX_PAIRS = y2n_pkg::DefaultMaxPairs
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [y2n_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [y2n_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        luma_a,
  input  logic [7:0]                        cb_in,
  input  logic [7:0]                        luma_b,
  input  logic [7:0]                        cr_in,
  input  logic                              frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        luma_out_a,
  output logic [7:0]                        luma_out_b,
  output logic                              chroma_valid,
  output logic [7:0]                        cb_out,
  output logic [7:0]                        cr_out,
  output logic                              line_end
);

  localparam int unsigned AddrWidth = $clog2(MAX_PAIRS);
  localparam int unsigned LenWidth = ($clog2(MAX_PAIRS + 1) > y2n_pkg::LinePairsWidth) ?
                                     $clog2(MAX_PAIRS + 1) : y2n_pkg::LinePairsWidth;
  localparam logic [LenWidth-1:0] MaxPairsLen = LenWidth'(MAX_PAIRS);
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(MAX_PAIRS - 1);

  logic [y2n_pkg::LinePairsWidth-1:0] line_pairs;
  logic                               interlaced;
  logic [AddrWidth-1:0]               column_count;
  logic [AddrWidth-1:0]               column_count_next;
  logic [1:0]                         line_phase;
  logic [1:0]                         line_phase_next;

  logic [LenWidth-1:0]  len_ext;
  logic [AddrWidth-1:0] last_col;
  logic [AddrWidth-1:0] cur_col;
  logic [1:0]           cur_phase;
  logic                 cur_last;
  logic [AddrWidth-1:0] col;
  y2n_pkg::mix_op_t     cur_op;
  y2n_pkg::store_cmd_t  cmd;

  logic                 in_accept;
  logic                 out_load;
  logic                 s1_valid;
  logic [7:0]           s1_luma_a;
  logic [7:0]           s1_luma_b;
  logic [7:0]           s1_cb;
  logic [7:0]           s1_cr;
  logic                 s1_last;
  y2n_pkg::mix_op_t     s1_op;
  logic [15:0]          rdata_first;
  logic [15:0]          rdata_second;
  logic [15:0]          stored;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pairs <= y2n_pkg::LinePairsReset;
      interlaced <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == y2n_pkg::RegLinePairs) begin
        line_pairs <= cfg_data;
      end else if (cfg_index == y2n_pkg::RegInterlaced) begin
        interlaced <= cfg_data[0];
      end
    end
  end

  assign len_ext = LenWidth'(line_pairs);

  always_comb begin
    priority if (len_ext == '0) begin
      last_col = '0;
    end else if (len_ext > MaxPairsLen) begin
      last_col = LastAddr;
    end else begin
      last_col = AddrWidth'(len_ext - LenWidth'(1));
    end
  end

  assign cur_col = frame_start ? '0 : column_count;
  assign cur_phase = frame_start ? 2'd0 : line_phase;
  assign cur_last = (cur_col >= last_col);
  assign col = cur_last ? last_col : cur_col;

  always_comb begin
    cmd = '0;
    cmd.rd = in_accept;
    cur_op = y2n_pkg::MIX_NONE;
    if (!interlaced) begin
      if (!cur_phase[0]) begin
        cmd.wr_first = in_accept;
      end else begin
        cur_op = y2n_pkg::MIX_AVERAGE;
      end
    end else begin
      unique case (cur_phase)
        2'd0: cmd.wr_first = in_accept;
        2'd1: cmd.wr_second = in_accept;
        2'd2: cur_op = y2n_pkg::MIX_HEAVY_STORED;
        2'd3: cur_op = y2n_pkg::MIX_HEAVY_CURRENT;
        default: cur_op = y2n_pkg::MIX_NONE;
      endcase
    end
  end

  assign column_count_next = cur_last ? '0 : cur_col + AddrWidth'(1);
  assign line_phase_next = cur_last ? cur_phase + 2'd1 : cur_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      line_phase <= 2'd0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      line_phase <= line_phase_next;
    end
  end

  y2n_line_store #(
    .MAX_PAIRS(MAX_PAIRS)
  ) u_store (
    .clk         (clk),
    .cmd         (cmd),
    .addr        (col),
    .wdata       ({cr_in, cb_in}),
    .rdata_first (rdata_first),
    .rdata_second(rdata_second)
  );

  assign out_load = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_luma_a <= luma_a;
      s1_luma_b <= luma_b;
      s1_cb <= cb_in;
      s1_cr <= cr_in;
      s1_last <= cur_last;
      s1_op <= cur_op;
    end
  end

  assign stored = (s1_op == y2n_pkg::MIX_HEAVY_CURRENT) ? rdata_second : rdata_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      luma_out_a <= s1_luma_a;
      luma_out_b <= s1_luma_b;
      chroma_valid <= (s1_op != y2n_pkg::MIX_NONE);
      cb_out <= y2n_pkg::chroma_mix(s1_op, stored[7:0], s1_cb);
      cr_out <= y2n_pkg::chroma_mix(s1_op, stored[15:8], s1_cr);
      line_end <= s1_last;
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for yuy2_to_nv12_chroma_downsampler_top: directed and random pixel pairs
// are checked against a line-store predictor of the 4:2:2 to 4:2:0 chroma conversion.
// Depends on y2n_pkg and the RTL of the block only.
module tb;

  localparam int unsigned StoreDepth = y2n_pkg::DefaultMaxPairs;
  localparam int unsigned IdleLimit = 2000;

  typedef struct packed {
    logic [7:0] ya;
    logic [7:0] cb;
    logic [7:0] yb;
    logic [7:0] cr;
    logic       fs;
  } yuy2_pair_t;

  typedef struct packed {
    logic [7:0] ya;
    logic [7:0] yb;
    logic       cvalid;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       lend;
  } nv12_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [y2n_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [y2n_pkg::CfgDataWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] luma_a = 8'd0;
  logic [7:0] cb_in = 8'd0;
  logic [7:0] luma_b = 8'd0;
  logic [7:0] cr_in = 8'd0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] luma_out_a;
  logic [7:0] luma_out_b;
  logic chroma_valid;
  logic [7:0] cb_out;
  logic [7:0] cr_out;
  logic line_end;

  yuy2_to_nv12_chroma_downsampler_top #(
    .MAX_PAIRS(StoreDepth)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .luma_a(luma_a),
    .cb_in(cb_in),
    .luma_b(luma_b),
    .cr_in(cr_in),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .luma_out_a(luma_out_a),
    .luma_out_b(luma_out_b),
    .chroma_valid(chroma_valid),
    .cb_out(cb_out),
    .cr_out(cr_out),
    .line_end(line_end)
  );

  always #5 clk = ~clk;

  yuy2_pair_t yuy2_backlog[$];
  nv12_pair_t nv12_awaited[$];
  int unsigned mismatch_count = 0;
  int unsigned pairs_queued = 0;
  bit sender_burst = 1'b0;
  bit receiver_burst = 1'b0;

  // Predictor state, updated only by accepted transactions and register writes.
  logic [10:0] pred_pairs = y2n_pkg::LinePairsReset;
  logic pred_interlaced = 1'b0;
  int unsigned pred_col = 0;
  logic [1:0] pred_phase = 2'd0;
  logic [15:0] pred_first [StoreDepth];
  logic [15:0] pred_second [StoreDepth];

  // Stimulus-side view of the block, used to keep reads away from unwritten store entries.
  logic [10:0] gen_pairs = y2n_pkg::LinePairsReset;
  logic gen_interlaced = 1'b0;
  int unsigned gen_col = 0;
  logic [1:0] gen_phase = 2'd0;
  bit gen_wrote_first [StoreDepth];
  bit gen_wrote_second [StoreDepth];

  function automatic int unsigned usable_pairs(input logic [10:0] pairs);
    if (pairs == 11'd0) return 1;
    if (pairs > StoreDepth) return StoreDepth;
    return pairs;
  endfunction

  function automatic logic [7:0] blend_chroma(input y2n_pkg::mix_op_t op,
                                              input logic [7:0] held,
                                              input logic [7:0] now);
    int unsigned s;
    case (op)
      y2n_pkg::MIX_AVERAGE: s = (held + now + 1) >> 1;
      y2n_pkg::MIX_HEAVY_STORED: s = (3 * held + now + 2) >> 2;
      y2n_pkg::MIX_HEAVY_CURRENT: s = (held + 3 * now + 2) >> 2;
      default: s = 0;
    endcase
    return s[7:0];
  endfunction

  function automatic nv12_pair_t predict_nv12_pair(input yuy2_pair_t p);
    int unsigned n;
    int unsigned col;
    logic line_done;
    y2n_pkg::mix_op_t op;
    logic [15:0] held;
    nv12_pair_t r;
    n = usable_pairs(pred_pairs);
    if (p.fs) begin
      pred_col = 0;
      pred_phase = 2'd0;
    end
    line_done = (pred_col >= n - 1);
    col = line_done ? n - 1 : pred_col;
    op = y2n_pkg::MIX_NONE;
    held = 16'd0;
    if (!pred_interlaced) begin
      if (!pred_phase[0]) begin
        pred_first[col] = {p.cr, p.cb};
      end else begin
        op = y2n_pkg::MIX_AVERAGE;
        held = pred_first[col];
      end
    end else begin
      case (pred_phase)
        2'd0: pred_first[col] = {p.cr, p.cb};
        2'd1: pred_second[col] = {p.cr, p.cb};
        2'd2: begin
          op = y2n_pkg::MIX_HEAVY_STORED;
          held = pred_first[col];
        end
        default: begin
          op = y2n_pkg::MIX_HEAVY_CURRENT;
          held = pred_second[col];
        end
      endcase
    end
    r.ya = p.ya;
    r.yb = p.yb;
    r.cvalid = (op != y2n_pkg::MIX_NONE);
    r.cb = blend_chroma(op, held[7:0], p.cb);
    r.cr = blend_chroma(op, held[15:8], p.cr);
    r.lend = line_done;
    if (line_done) begin
      pred_col = 0;
      pred_phase = pred_phase + 2'd1;
    end else begin
      pred_col = pred_col + 1;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // A pair that would read a never-written store entry is turned into a frame start.
  task automatic queue_pair(input logic [7:0] ya, input logic [7:0] cb, input logic [7:0] yb,
                            input logic [7:0] cr, input logic fs);
    int unsigned n;
    int unsigned col;
    logic line_done;
    logic hazard;
    n = usable_pairs(gen_pairs);
    col = (gen_col >= n - 1) ? n - 1 : gen_col;
    if (gen_interlaced) begin
      hazard = (gen_phase == 2'd2 && !gen_wrote_first[col]) ||
               (gen_phase == 2'd3 && !gen_wrote_second[col]);
    end else begin
      hazard = gen_phase[0] && !gen_wrote_first[col];
    end
    if (hazard) fs = 1'b1;
    if (fs) begin
      gen_col = 0;
      gen_phase = 2'd0;
      col = 0;
    end
    line_done = (gen_col >= n - 1);
    if (gen_phase == 2'd0 || (!gen_interlaced && gen_phase == 2'd2)) begin
      gen_wrote_first[col] = 1'b1;
    end else if (gen_interlaced && gen_phase == 2'd1) begin
      gen_wrote_second[col] = 1'b1;
    end
    if (line_done) begin
      gen_col = 0;
      gen_phase = gen_phase + 2'd1;
    end else begin
      gen_col = gen_col + 1;
    end
    yuy2_backlog.push_back('{ya: ya, cb: cb, yb: yb, cr: cr, fs: fs});
    pairs_queued++;
  endtask

  task automatic queue_random_pair(input logic fs);
    queue_pair($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), fs);
  endtask

  task automatic wait_for_idle();
    do @(negedge clk); while (yuy2_backlog.size() != 0 || nv12_awaited.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [y2n_pkg::CfgIndexWidth-1:0] idx,
                           input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[y2n_pkg::CfgDataWidth-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == y2n_pkg::RegLinePairs) begin
      pred_pairs = value[10:0];
      gen_pairs = value[10:0];
    end else begin
      pred_interlaced = value[0];
      gen_interlaced = value[0];
    end
    @(negedge clk);
  endtask

  // Pixel pair driver.
  int unsigned send_wait = 0;
  always @(posedge clk) begin
    int unsigned gap;
    logic send_now;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      send_now = 1'b0;
      if (in_valid && !in_stall) begin
        nv12_awaited.push_back(predict_nv12_pair({luma_a, cb_in, luma_b, cr_in, frame_start}));
        void'(yuy2_backlog.pop_front());
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        send_now = (gap == 0 && yuy2_backlog.size() != 0);
        send_wait <= gap;
      end else if (!in_valid) begin
        if (send_wait != 0) send_wait <= send_wait - 1;
        else send_now = (yuy2_backlog.size() != 0);
      end
      if (send_now) begin
        {luma_a, cb_in, luma_b, cr_in, frame_start} <= yuy2_backlog[0];
      end
      in_valid <= send_now || (in_valid && in_stall);
    end
  end

  // Result monitor and output stall generator.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    nv12_pair_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (nv12_awaited.size() == 0) begin
          $error("result transaction with no pixel pair outstanding");
          mismatch_count++;
        end else begin
          want = nv12_awaited.pop_front();
          check_field("luma_out_a", want.ya, luma_out_a);
          check_field("luma_out_b", want.yb, luma_out_b);
          check_field("chroma_valid", want.cvalid, chroma_valid);
          check_field("cb_out", want.cb, cb_out);
          check_field("cr_out", want.cr, cr_out);
          check_field("line_end", want.lend, line_end);
        end
        stall_left = receiver_burst ? 0 : $urandom_range(0, 14);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned pairs;
    int unsigned total;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Progressive averaging at the byte extremes, then a frame start in mid line.
    write_reg(y2n_pkg::RegLinePairs, 2);
    write_reg(y2n_pkg::RegInterlaced, 0);
    queue_pair(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pair(8'h00, 8'h01, 8'h00, 8'h02, 1'b0);
    queue_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);
    queue_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1);
    wait_for_idle();

    // Interlaced weighting with a zero line length, which acts as one pair.
    write_reg(y2n_pkg::RegLinePairs, 0);
    write_reg(y2n_pkg::RegInterlaced, 1);
    queue_pair(8'h12, 8'hFF, 8'h34, 8'h00, 1'b1);
    queue_pair(8'h56, 8'h00, 8'h78, 8'hFF, 1'b0);
    queue_pair(8'h9A, 8'h00, 8'hBC, 8'hFF, 1'b0);
    queue_pair(8'hDE, 8'hFF, 8'hF0, 8'h00, 1'b0);
    queue_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    wait_for_idle();

    // Shortening the line in mid line puts the column past the end.
    write_reg(y2n_pkg::RegLinePairs, 4);
    write_reg(y2n_pkg::RegInterlaced, 0);
    queue_pair(8'h01, 8'h10, 8'h02, 8'h20, 1'b1);
    queue_pair(8'h03, 8'h30, 8'h04, 8'h40, 1'b0);
    wait_for_idle();
    write_reg(y2n_pkg::RegLinePairs, 2);
    queue_pair(8'h05, 8'h50, 8'h06, 8'h60, 1'b0);
    queue_pair(8'h07, 8'h70, 8'h08, 8'h80, 1'b0);
    queue_pair(8'h09, 8'h90, 8'h0A, 8'hA0, 1'b0);
    wait_for_idle();

    // Mode change in mid frame.
    write_reg(y2n_pkg::RegInterlaced, 1);
    queue_random_pair(1'b0);
    queue_random_pair(1'b0);
    wait_for_idle();

    // Oversized line length, limited to the store depth.
    write_reg(y2n_pkg::RegLinePairs, 2047);
    write_reg(y2n_pkg::RegInterlaced, 0);
    sender_burst = ($urandom_range(0, 1) == 0);
    receiver_burst = ($urandom_range(0, 1) == 0);
    for (int k = 0; k < StoreDepth + 64; k++) queue_random_pair(k == 0);

    phase_no = 0;
    while (pairs_queued < 1800) begin
      wait_for_idle();
      pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
      write_reg(y2n_pkg::RegInterlaced, $urandom_range(0, 1));
      write_reg(y2n_pkg::RegLinePairs, pairs);
      sender_burst = ($urandom_range(0, 3) == 0);
      receiver_burst = ($urandom_range(0, 3) == 0);
      total = $urandom_range(4, 12) * usable_pairs(pairs[10:0]);
      for (int k = 0; k < total; k++) begin
        if (phase_no == 3 && k == total / 2) wait_for_idle();
        queue_random_pair((k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 59) == 0);
      end
      phase_no++;
    end

    wait_for_idle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && nv12_awaited.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
